>>> rtl/fpa_pkg.sv
package fpa_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 8;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

  localparam logic [3:0] OP_ADD      = 4'd0;
  localparam logic [3:0] OP_SUB      = 4'd1;
  localparam logic [3:0] OP_MUL      = 4'd2;
  localparam logic [3:0] OP_DIV      = 4'd3;
  localparam logic [3:0] OP_GT       = 4'd4;
  localparam logic [3:0] OP_LT       = 4'd5;
  localparam logic [3:0] OP_GE       = 4'd6;
  localparam logic [3:0] OP_LE       = 4'd7;
  localparam logic [3:0] OP_EQ       = 4'd8;
  localparam logic [3:0] OP_NE       = 4'd9;
  localparam logic [3:0] OP_MIN      = 4'd10;
  localparam logic [3:0] OP_MAX      = 4'd11;
  localparam logic [3:0] OP_INC      = 4'd12;
  localparam logic [3:0] OP_DEC      = 4'd13;
  localparam logic [3:0] OP_TO_INT   = 4'd14;
  localparam logic [3:0] OP_FROM_INT = 4'd15;

  // classified item handed from the front to the back
  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] res;
    logic              cmp;
    logic              is_mul;
    logic              is_div;
    logic              dz;
  } fpa_item_t;

endpackage

>>> rtl/fpa_front.sv
module fpa_front #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic [3:0]                 operation,
  input  logic [fpa_pkg::DATA_W-1:0] operand_a,
  input  logic [fpa_pkg::DATA_W-1:0] operand_b,
  output fpa_pkg::fpa_item_t         item
);
  import fpa_pkg::*;

  logic signed [DATA_W-1:0] sa;
  logic signed [DATA_W-1:0] sb;
  logic [DATA_W-1:0]        mag_a;
  logic [DATA_W-1:0]        int_mag;
  logic                     lt;
  logic                     gt;
  logic                     eq;

  assign sa      = operand_a;
  assign sb      = operand_b;
  assign lt      = sa < sb;
  assign gt      = sa > sb;
  assign eq      = operand_a == operand_b;
  assign mag_a   = operand_a[DATA_W-1] ? (DATA_W'(0) - operand_a) : operand_a;
  assign int_mag = mag_a >> FRAC_BITS;

  always_comb begin
    item        = '0;
    item.a      = operand_a;
    item.b      = operand_b;
    case (operation)
      OP_ADD:      item.res = operand_a + operand_b;
      OP_SUB:      item.res = operand_a - operand_b;
      OP_MUL:      item.is_mul = 1'b1;
      OP_DIV: begin
        // zero divisor is settled here and skips the divider
        if (operand_b == '0) begin
          item.dz = 1'b1;
        end else begin
          item.is_div = 1'b1;
        end
      end
      OP_GT:       item.cmp = gt;
      OP_LT:       item.cmp = lt;
      OP_GE:       item.cmp = !lt;
      OP_LE:       item.cmp = !gt;
      OP_EQ:       item.cmp = eq;
      OP_NE:       item.cmp = !eq;
      OP_MIN:      item.res = lt ? operand_a : operand_b;
      OP_MAX:      item.res = gt ? operand_a : operand_b;
      OP_INC:      item.res = operand_a + DATA_W'(1);
      OP_DEC:      item.res = operand_a - DATA_W'(1);
      OP_TO_INT:   item.res = operand_a[DATA_W-1] ? (DATA_W'(0) - int_mag) : int_mag;
      OP_FROM_INT: item.res = operand_a << FRAC_BITS;
      default:     item.res = '0;
    endcase
  end

endmodule

>>> rtl/fpa_queue.sv
module fpa_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fpa_pkg::fpa_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output fpa_pkg::fpa_item_t pop_item
);
  import fpa_pkg::*;

  fpa_item_t            mem_r [QUEUE_DEPTH];
  fpa_item_t            head_r;
  logic [QUEUE_AW-1:0]  wr_ptr_r;
  logic [QUEUE_AW-1:0]  rd_ptr_r;
  logic [QUEUE_AW-1:0]  rd_ptr_nxt;
  logic [QUEUE_AW:0]    count_r;
  logic [QUEUE_AW:0]    count_nxt;

  assign full      = count_r == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign pop_item  = head_r;

  always_comb begin
    count_nxt  = count_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push && !pop) begin
      count_nxt = count_r + (QUEUE_AW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QUEUE_AW+1)'(1);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + QUEUE_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r  <= count_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // head is registered from rd_ptr_nxt; a push into the head slot bypasses the array
  always_ff @(posedge clk) begin
    if (push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= push_item;
    end else begin
      head_r <= mem_r[rd_ptr_nxt];
    end
  end

endmodule

>>> rtl/fpa_back.sv
module fpa_back #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       item_valid,
  input  fpa_pkg::fpa_item_t         item,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [fpa_pkg::DATA_W-1:0] out_result,
  output logic                       out_cmp,
  output logic                       out_dz
);
  import fpa_pkg::*;

  localparam int NW = DATA_W + FRAC_BITS;

  logic adv;

  // stage 0 plus one stage per quotient bit
  logic              v_r     [NW+1];
  logic              isdiv_r [NW+1];
  logic              cmp_r   [NW+1];
  logic              dz_r    [NW+1];
  logic              neg_r   [NW+1];
  logic [DATA_W-1:0] res_r   [NW+1];
  logic [DATA_W-1:0] d_r     [NW+1];
  logic [DATA_W-1:0] rem_r   [NW+1];
  logic [DATA_W-1:0] q_r     [NW+1];
  logic [NW-1:0]     nsh_r   [NW+1];

  logic                     ismul_r;
  logic signed [2*DATA_W-1:0] prod_r;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_result_r;
  logic              out_cmp_r;
  logic              out_dz_r;

  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;
  logic              rnd;
  logic [DATA_W-1:0] div_res;

  // whole pipeline moves together; output register parts it from the sink
  assign adv = !out_valid_r || out_ready;
  assign pop = adv && item_valid;

  assign mag_a = item.a[DATA_W-1] ? (DATA_W'(0) - item.a) : item.a;
  assign mag_b = item.b[DATA_W-1] ? (DATA_W'(0) - item.b) : item.b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      isdiv_r[0] <= item.is_div;
      ismul_r    <= item.is_mul;
      cmp_r[0]   <= item.cmp;
      dz_r[0]    <= item.dz;
      neg_r[0]   <= item.a[DATA_W-1] ^ item.b[DATA_W-1];
      res_r[0]   <= item.res;
      d_r[0]     <= mag_b;
      rem_r[0]   <= '0;
      q_r[0]     <= '0;
      nsh_r[0]   <= {mag_a, FRAC_BITS'(0)};
      prod_r     <= $signed(item.a) * $signed(item.b);
    end
  end

  for (genvar k = 1; k <= NW; k++) begin : g_stage
    logic [DATA_W:0]   trial;
    logic              ge;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] res_in;

    assign trial = {rem_r[k-1], nsh_r[k-1][NW-1]};
    assign ge    = trial >= {1'b0, d_r[k-1]};
    assign diff  = trial - {1'b0, d_r[k-1]};

    if (k == 1) begin : g_mul
      // floor shift of the product is an arithmetic slice
      assign res_in = ismul_r ? prod_r[FRAC_BITS+DATA_W-1:FRAC_BITS] : res_r[0];
    end else begin : g_pass
      assign res_in = res_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        isdiv_r[k] <= isdiv_r[k-1];
        cmp_r[k]   <= cmp_r[k-1];
        dz_r[k]    <= dz_r[k-1];
        neg_r[k]   <= neg_r[k-1];
        res_r[k]   <= res_in;
        d_r[k]     <= d_r[k-1];
        rem_r[k]   <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        q_r[k]     <= {q_r[k-1][DATA_W-2:0], ge};
        nsh_r[k]   <= {nsh_r[k-1][NW-2:0], 1'b0};
      end
    end
  end

  // round half away from zero: bump when twice the remainder reaches the divisor
  assign rnd     = {rem_r[NW], 1'b0} >= {1'b0, d_r[NW]};
  assign div_res = neg_r[NW] ? (~q_r[NW] + DATA_W'(!rnd)) : (q_r[NW] + DATA_W'(rnd));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_result_r <= isdiv_r[NW] ? div_res : res_r[NW];
      out_cmp_r    <= cmp_r[NW];
      out_dz_r     <= dz_r[NW];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_cmp    = out_cmp_r;
  assign out_dz     = out_dz_r;

endmodule

>>> rtl/fixed_point_alu_q24_8.sv
// throughput: one item per cycle while out_tready is held high; every operation flows
// through the same one-quotient-bit-per-stage divide pipeline behind a 4-entry queue
// reset (rst_n low, synchronous): empties the queue and clears all stage valid bits,
// data registers are not reset
module fixed_point_alu_q24_8 #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] operation, [35:4] operand_a, [67:36] operand_b, [71:68] zero
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] result_value, [32] compare_true, [33] divide_by_zero, [39:34] zero
  output logic [39:0] out_tdata
);
  import fpa_pkg::*;

  fpa_item_t         front_item;
  fpa_item_t         queue_item;
  logic              queue_full;
  logic              queue_not_empty;
  logic              pop;
  logic              push;
  logic [DATA_W-1:0] result;
  logic              cmp;
  logic              dz;

  assign in_tready = !queue_full;
  assign push      = in_tvalid && !queue_full;

  fpa_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .operation (in_tdata[3:0]),
    .operand_a (in_tdata[35:4]),
    .operand_b (in_tdata[67:36]),
    .item      (front_item)
  );

  fpa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (queue_not_empty),
    .pop_item  (queue_item)
  );

  fpa_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (queue_not_empty),
    .item       (queue_item),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (result),
    .out_cmp    (cmp),
    .out_dz     (dz)
  );

  assign out_tdata = {6'b0, dz, cmp, result};

endmodule

>>> dv/fixed_point_alu_q24_8_tb.sv
class alu_results;
  typedef struct {
    logic [3:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] value;
    logic        cmp;
    logic        dz;
  } alu_outcome_t;

  alu_outcome_t awaited[$];
  int           mismatches = 0;

  function alu_outcome_t compute_alu(logic [3:0] op, logic [31:0] a, logic [31:0] b);
    alu_outcome_t  o;
    longint        sa;
    longint        sb;
    longint        wide;
    longint unsigned num;
    longint unsigned den;
    longint unsigned quo;
    sa = longint'(signed'(a));
    sb = longint'(signed'(b));
    o.op = op;
    o.a = a;
    o.b = b;
    o.cmp = 1'b0;
    o.dz = 1'b0;
    wide = 0;
    case (op)
      fpa_pkg::OP_ADD: begin
        wide = sa + sb;
      end
      fpa_pkg::OP_SUB: begin
        wide = sa - sb;
      end
      fpa_pkg::OP_MUL: begin
        // full 64-bit product, arithmetic shift gives the floor
        wide = (sa * sb) >>> fpa_pkg::FRAC_BITS_DEF;
      end
      fpa_pkg::OP_DIV: begin
        if (sb == 0) begin
          o.dz = 1'b1;
        end else begin
          num = ((sa < 0) ? -sa : sa) << fpa_pkg::FRAC_BITS_DEF;
          den = (sb < 0) ? -sb : sb;
          // half away from zero on magnitudes
          quo = (2 * num + den) / (2 * den);
          wide = ((sa < 0) != (sb < 0)) ? -longint'(quo) : longint'(quo);
        end
      end
      fpa_pkg::OP_GT: o.cmp = (sa > sb);
      fpa_pkg::OP_LT: o.cmp = (sa < sb);
      fpa_pkg::OP_GE: o.cmp = (sa >= sb);
      fpa_pkg::OP_LE: o.cmp = (sa <= sb);
      fpa_pkg::OP_EQ: o.cmp = (sa == sb);
      fpa_pkg::OP_NE: o.cmp = (sa != sb);
      fpa_pkg::OP_MIN: wide = (sa < sb) ? sa : sb;
      fpa_pkg::OP_MAX: wide = (sa > sb) ? sa : sb;
      fpa_pkg::OP_INC: wide = sa + 1;
      fpa_pkg::OP_DEC: wide = sa - 1;
      fpa_pkg::OP_TO_INT: begin
        // truncate toward zero
        quo = ((sa < 0) ? -sa : sa) >> fpa_pkg::FRAC_BITS_DEF;
        wide = (sa < 0) ? -longint'(quo) : longint'(quo);
      end
      default: begin
        wide = sa << fpa_pkg::FRAC_BITS_DEF;
      end
    endcase
    o.value = wide[31:0];
    return o;
  endfunction

  function void note_operation(logic [3:0] op, logic [31:0] a, logic [31:0] b);
    awaited.push_back(compute_alu(op, a, b));
  endfunction

  function void check_result(logic [39:0] data);
    alu_outcome_t e;
    if (awaited.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected result item: value %h cmp %b dz %b",
                 data[31:0], data[32], data[33]);
      mismatches++;
    end else begin
      e = awaited.pop_front();
      if (data[31:0] !== e.value || data[32] !== e.cmp || data[33] !== e.dz) begin
        if (mismatches < 10)
          $display("op %0d a %h b %h: expected value %h cmp %b dz %b, got value %h cmp %b dz %b",
                   e.op, e.a, e.b, e.value, e.cmp, e.dz, data[31:0], data[32], data[33]);
        mismatches++;
      end
    end
  endfunction
endclass

module fixed_point_alu_q24_8_tb;
  import fpa_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 60;
  localparam int HOLD_CYCLES  = 300;
  localparam int BURST_ITEMS  = 120;
  localparam int RANDOM_ITEMS = 1300;
  localparam int STEADY_ITEMS = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  bit          hold_req = 1'b0;
  bit          steady = 1'b0;
  int          cycles = 0;
  alu_results  book = new();

  fixed_point_alu_q24_8 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("fixed_point_alu_q24_8_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) book.check_result(out_tdata);
  end

  // result side: random ready bursts, one long hold on request, none in the tail
  initial begin
    bit rdy;
    int run;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (steady) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        rdy = ($urandom_range(0, 2) != 0);
        run = rdy ? $urandom_range(1, 40) : $urandom_range(1, 18);
        out_tready <= rdy;
        repeat (run) @(posedge clk);
      end
    end
  end

  task automatic push_item(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, b, a, op};
    do @(posedge clk); while (!in_tready);
    book.note_operation(op, a, b);
  endtask

  task automatic idle_in(input int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (book.awaited.size() != 0);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'hffff_ffff;
      4: return 32'($urandom_range(0, 2048)) - 32'd1024;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_random();
    logic [31:0] a;
    logic [31:0] b;
    a = pick_operand();
    // equal operands now and then for compare, min and max ties
    b = ($urandom_range(0, 7) == 0) ? a : pick_operand();
    push_item(4'($urandom_range(0, 15)), a, b);
  endtask

  initial begin
    int i;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_item(OP_ADD,      32'h7fff_ffff, 32'h0000_0001);
    push_item(OP_ADD,      32'h8000_0000, 32'h8000_0000);
    push_item(OP_SUB,      32'h8000_0000, 32'h0000_0001);
    push_item(OP_MUL,      32'h7fff_ffff, 32'h7fff_ffff);
    push_item(OP_MUL,      32'h8000_0000, 32'h8000_0000);
    push_item(OP_MUL,      32'hffff_ffff, 32'h0000_0001);
    push_item(OP_DIV,      32'h0000_0100, 32'h0000_0000);
    push_item(OP_DIV,      32'h8000_0000, 32'hffff_ffff);
    push_item(OP_DIV,      32'h0000_0001, 32'h0000_0200);
    push_item(OP_DIV,      32'hffff_ffff, 32'h0000_0200);
    push_item(OP_DIV,      32'h7fff_ffff, 32'h8000_0000);
    push_item(OP_GT,       32'h7fff_ffff, 32'h8000_0000);
    push_item(OP_LT,       32'h8000_0000, 32'h7fff_ffff);
    push_item(OP_GE,       32'h0000_0005, 32'h0000_0005);
    push_item(OP_LE,       32'h0000_0005, 32'h0000_0005);
    push_item(OP_EQ,       32'h8000_0000, 32'h8000_0000);
    push_item(OP_NE,       32'h0000_0000, 32'hffff_ffff);
    push_item(OP_MIN,      32'h0000_0123, 32'h0000_0123);
    push_item(OP_MAX,      32'h8000_0000, 32'h7fff_ffff);
    push_item(OP_INC,      32'h7fff_ffff, 32'hffff_ffff);
    push_item(OP_DEC,      32'h8000_0000, 32'h0000_0000);
    push_item(OP_TO_INT,   32'hffff_ff01, 32'h0000_0000);
    push_item(OP_TO_INT,   32'h8000_0000, 32'h7fff_ffff);
    push_item(OP_FROM_INT, 32'h0080_0000, 32'h0000_0000);
    push_item(OP_FROM_INT, 32'hffff_ffff, 32'h8000_0000);
    wait_drained();

    // back to back items against a stalled result side
    hold_req = 1'b1;
    repeat (BURST_ITEMS) push_random();
    wait_drained();

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - STEADY_ITEMS) steady = 1'b1;
      if (!steady && $urandom_range(0, 4) == 0) idle_in($urandom_range(1, 18));
      push_random();
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (book.mismatches == 0) begin
      $display("fixed_point_alu_q24_8_tb: PASS");
    end else begin
      $display("fixed_point_alu_q24_8_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/fpa_pkg.sv
rtl/fpa_front.sv
rtl/fpa_queue.sv
rtl/fpa_back.sv
rtl/fixed_point_alu_q24_8.sv
dv/fixed_point_alu_q24_8_tb.sv
